FILE: rtl/rfbq_pkg.sv
// Package for the ring FIFO burst queue: sizes, command and status codes,
// and the packed request and response transaction types.
// No dependencies.
package rfbq_pkg;

  // ring geometry
  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = $clog2(DEPTH);

  // fixed field widths
  localparam int CNT_BITS  = 6;
  localparam int FILL_BITS = 6;
  localparam int DATA_BITS = 32;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_PUSH_OK   = 2'd0,
    ST_PUSH_FULL = 2'd1,
    ST_POP_WORD  = 2'd2,
    ST_POP_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [DATA_BITS-1:0] push_word;
    logic [CNT_BITS-1:0]  pop_count;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [DATA_BITS-1:0] pop_word;
    logic                 last;
    logic [FILL_BITS-1:0] fill_level;
  } rsp_t;

endpackage

FILE: rtl/ring_fifo_burst_queue.sv
// Top level of the ring FIFO burst queue: pointers, burst sequencer and
// response register around the slot memory.
// Depends on rfbq_pkg and rfbq_ram.
//
//  channel  | valid      | stall      | payload
//  ---------+------------+------------+-------------------
//  request  | req_valid  | req_stall  | req (rfbq_pkg::req_t)
//  response | rsp_valid  | rsp_stall  | rsp (rfbq_pkg::rsp_t)
//
// A push gives one response; pushes flow one per cycle unless the response
// is stalled. A pop of n words starts the burst, reads the memory, gives n
// responses at one per cycle set by the single read port unless stalled,
// and returns to idle. An empty or zero-count pop gives one empty response.
// Reset clears both pointers; no clearing pass is needed. Response stall
// backs up the burst and holds off new requests until the register drains.
module ring_fifo_burst_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rfbq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rfbq_pkg::rsp_t rsp
);

  localparam int ADDR_BITS = rfbq_pkg::ADDR_BITS;
  localparam int CNT_BITS  = rfbq_pkg::CNT_BITS;
  localparam int CMP_BITS  = (ADDR_BITS > CNT_BITS) ? ADDR_BITS : CNT_BITS;

  typedef enum logic [0:0] {
    S_IDLE,
    S_POP
  } state_t;

  state_t                        state;
  logic [ADDR_BITS-1:0]          wr_ptr;
  logic [ADDR_BITS-1:0]          rd_ptr;
  logic [CNT_BITS-1:0]           remaining;
  logic                          q_valid;
  logic                          q_last;
  logic [ADDR_BITS-1:0]          q_fill;

  logic                          acc;
  logic                          out_free;
  logic                          move;
  logic                          issue;
  logic                          full;
  logic                          push_ok;
  logic                          rsp_load;
  logic [ADDR_BITS-1:0]          fill;
  logic [ADDR_BITS-1:0]          fill_inc;
  logic [ADDR_BITS-1:0]          fill_dec;
  logic [CNT_BITS-1:0]           take;
  logic [rfbq_pkg::WORD_BITS-1:0] ram_q;

  // occupancy and handshake
  always_comb begin
    fill     = wr_ptr - rd_ptr;
    fill_inc = fill + ADDR_BITS'(1);
    fill_dec = fill - ADDR_BITS'(1);
    full     = (fill == ADDR_BITS'(rfbq_pkg::DEPTH - 1));
    out_free = !rsp_valid || !rsp_stall;
    req_stall = (state != S_IDLE) || !out_free;
    acc      = req_valid && !req_stall;
    push_ok  = acc && (req.cmd == rfbq_pkg::CMD_PUSH) && !full;
    move     = q_valid && out_free;
    issue    = (state == S_POP) && (remaining != '0) && (!q_valid || move);
  end

  // burst length is the smaller of request count and fill
  always_comb begin
    if (CMP_BITS'(req.pop_count) < CMP_BITS'(fill)) begin
      take = req.pop_count;
    end else begin
      take = CNT_BITS'(fill);
    end
    rsp_load = (acc && ((req.cmd == rfbq_pkg::CMD_PUSH) || (take == '0))) ||
               ((state == S_POP) && move);
  end

  // slot memory: written on push in idle, read only during a burst
  rfbq_ram #(
    .ADDR_BITS(ADDR_BITS),
    .DATA_BITS(rfbq_pkg::WORD_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (push_ok),
    .waddr(wr_ptr),
    .wdata(rfbq_pkg::WORD_BITS'(req.push_word)),
    .re   (issue),
    .raddr(rd_ptr),
    .rdata(ram_q)
  );

  // sequencer, pointers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      remaining <= '0;
      q_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // response register valid
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (req.cmd == rfbq_pkg::CMD_PUSH) begin
              rsp.pop_word   <= '0;
              rsp.last       <= 1'b1;
              if (full) begin
                rsp.status     <= rfbq_pkg::ST_PUSH_FULL;
                rsp.fill_level <= rfbq_pkg::FILL_BITS'(fill);
              end else begin
                wr_ptr         <= wr_ptr + ADDR_BITS'(1);
                rsp.status     <= rfbq_pkg::ST_PUSH_OK;
                rsp.fill_level <= rfbq_pkg::FILL_BITS'(fill_inc);
              end
            end else if (take == '0) begin
              rsp.status     <= rfbq_pkg::ST_POP_EMPTY;
              rsp.pop_word   <= '0;
              rsp.last       <= 1'b1;
              rsp.fill_level <= rfbq_pkg::FILL_BITS'(fill);
            end else begin
              remaining <= take;
              state     <= S_POP;
            end
          end
        end
        S_POP: begin
          // read issue into the memory output stage
          if (issue) begin
            rd_ptr    <= rd_ptr + ADDR_BITS'(1);
            remaining <= remaining - CNT_BITS'(1);
            q_valid   <= 1'b1;
            q_last    <= (remaining == CNT_BITS'(1));
            q_fill    <= fill_dec;
          end else if (move) begin
            q_valid <= 1'b0;
          end
          // memory output stage into the response register
          if (move) begin
            rsp.status     <= rfbq_pkg::ST_POP_WORD;
            rsp.pop_word   <= rfbq_pkg::DATA_BITS'(ram_q);
            rsp.last       <= q_last;
            rsp.fill_level <= rfbq_pkg::FILL_BITS'(q_fill);
          end
          if ((remaining == '0) && !q_valid) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a burst count is only held while a burst runs
  a_remaining_in_pop: assert property (@(posedge clk) disable iff (rst)
    (remaining != '0) |-> (state == S_POP))
    else $error("burst count held outside a burst");

  // the memory output stage is only loaded during a burst
  a_q_in_pop: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (state == S_POP))
    else $error("memory stage valid outside a burst");

  // the last word of a burst leaves nothing more to read
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_last) |-> (remaining == '0))
    else $error("last word issued with reads outstanding");

  // an accepted push into a non-full ring advances the write pointer
  a_push_advance: assert property (@(posedge clk) disable iff (rst)
    push_ok |=> (wr_ptr == $past(wr_ptr) + ADDR_BITS'(1)))
    else $error("write pointer did not advance on push");

  // a burst never reads past the write pointer
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    issue |-> (fill != '0))
    else $error("burst read from an empty ring");
`endif

endmodule

FILE: rtl/rfbq_ram.sv
// Simple dual-port slot memory for the ring FIFO burst queue.
// One write port, one read port with registered data held while not enabled.
// No dependencies.
module rfbq_ram #(
  parameter int ADDR_BITS = 6,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
